@@ sv/source_text_tokenizer_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the source text tokenizer
// Concurrent checks that drop out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`define SOURCE_TEXT_TOKENIZER_ASSERT_SVH
`ifndef SYNTH
// A condition that must hold at every clock edge outside reset.
`define STT_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("tokenizer check failed");
// A condition that must hold in the cycle after a trigger.
`define STT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("tokenizer check failed");
`else
`define STT_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define STT_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

@@ sv/stt_pkg.sv @@
// ----------------------------------------------------------------------------
// stt_pkg
// Types, codes and character tables shared by the tokenizer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package stt_pkg;

  // Token lengths are carried in six bits, enough for up to 63 bytes.
  localparam int unsigned TLEN_W    = 6;
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = 2;

  localparam logic [5:0] K_DIVIDE  = 6'd11;
  localparam logic [5:0] K_COMMENT = 6'd10;
  localparam logic [5:0] K_STRING  = 6'd14;
  localparam logic [5:0] K_FLOAT   = 6'd25;
  localparam logic [5:0] K_INT     = 6'd26;
  localparam logic [5:0] K_IDENT   = 6'd27;
  localparam logic [5:0] K_KW0     = 6'd28;
  localparam logic [5:0] K_EOF     = 6'd37;
  localparam logic [5:0] K_NONE    = 6'd63;

  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_UNKNOWN  = 3'd1;
  localparam logic [2:0] E_FRACTION = 3'd2;
  localparam logic [2:0] E_STRING   = 3'd3;
  localparam logic [2:0] E_OVERFLOW = 3'd4;

  typedef enum logic [1:0] {OP_APPEND, OP_EMIT, OP_ERROR, OP_END} op_e;
  typedef enum logic [1:0] {SRC_BUF, SRC_CHR, SRC_KW, SRC_EOF} src_e;

  // One command from the front to the back.
  typedef struct packed {
    op_e         op;
    src_e        src;
    logic [5:0]  kind;
    logic [7:0]  ch;
    logic        tend;
    logic [5:0]  len;    // text length, or the write index of an append
    logic [3:0]  kw;
    logic [2:0]  ecode;
    logic [15:0] epos;
  } stt_cmd_t;

  // One result item before the run end mark is known.
  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  ch;
    logic        tend;
    logic [2:0]  ecode;
    logic [15:0] epos;
  } stt_res_t;

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    case (k)
      4'd0, 4'd5:               return 3'd2;
      4'd2, 4'd4, 4'd6:         return 3'd3;
      4'd1, 4'd7:               return 3'd4;
      4'd3, 4'd8:               return 3'd5;
      default:                  return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] i);
    logic [39:0] t;
    case (k)
      4'd0:    t = {"IF", 24'd0};
      4'd1:    t = {"ELSE", 8'd0};
      4'd2:    t = {"FOR", 16'd0};
      4'd3:    t = "WHILE";
      4'd4:    t = {"LET", 16'd0};
      4'd5:    t = {"IN", 24'd0};
      4'd6:    t = {"OUT", 16'd0};
      4'd7:    t = {"TRUE", 8'd0};
      4'd8:    t = "FALSE";
      default: t = '0;
    endcase
    case (i)
      3'd0:    return t[39:32];
      3'd1:    return t[31:24];
      3'd2:    return t[23:16];
      3'd3:    return t[15:8];
      3'd4:    return t[7:0];
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] eof_char(input logic [2:0] i);
    case (i)
      3'd0:    return "E";
      3'd1:    return "O";
      3'd2:    return "F";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= "a" && c <= "z") ? c - 8'd32 : c;
  endfunction

  function automatic logic [5:0] single_kind(input logic [7:0] c);
    case (c)
      "-":     return 6'd0;
      "+":     return 6'd1;
      "*":     return 6'd2;
      ";":     return 6'd3;
      "(":     return 6'd4;
      ")":     return 6'd5;
      "{":     return 6'd6;
      "}":     return 6'd7;
      "[":     return 6'd8;
      "]":     return 6'd9;
      "#":     return 6'd12;
      "?":     return 6'd13;
      default: return K_NONE;
    endcase
  endfunction

  // Pending operator codes: 1 slash, 2 equals, 3 greater, 4 less, 5 bang,
  // 6 ampersand, 7 bar.
  function automatic logic [2:0] pend_code(input logic [7:0] c);
    case (c)
      "/":     return 3'd1;
      "=":     return 3'd2;
      ">":     return 3'd3;
      "<":     return 3'd4;
      "!":     return 3'd5;
      "&":     return 3'd6;
      "|":     return 3'd7;
      default: return 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] pend_char(input logic [2:0] p);
    case (p)
      3'd1:    return "/";
      3'd2:    return "=";
      3'd3:    return ">";
      3'd4:    return "<";
      3'd5:    return "!";
      3'd6:    return "&";
      3'd7:    return "|";
      default: return 8'd0;
    endcase
  endfunction

  function automatic logic [5:0] pend_single(input logic [2:0] p);
    case (p)
      3'd1:    return 6'd11;
      3'd2:    return 6'd16;
      3'd3:    return 6'd18;
      3'd4:    return 6'd20;
      3'd5:    return 6'd22;
      default: return 6'd0;
    endcase
  endfunction

  function automatic logic [5:0] pend_double(input logic [2:0] p);
    case (p)
      3'd2:    return 6'd15;
      3'd3:    return 6'd17;
      3'd4:    return 6'd19;
      3'd5:    return 6'd21;
      3'd6:    return 6'd23;
      3'd7:    return 6'd24;
      default: return 6'd0;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ sv/stt_ram.sv @@
// ----------------------------------------------------------------------------
// stt_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ sv/stt_front.sv @@
// ----------------------------------------------------------------------------
// stt_front
// Accepts source bytes, tracks the lexer mode and issues commands to the back.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_front #(
  parameter int unsigned TOKEN_BYTES   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        text_byte_i,
  input  logic              final_byte_i,
  output logic              push_o,
  output stt_pkg::stt_cmd_t cmd_o,
  input  logic              full_i
);
  import stt_pkg::*;

  localparam int unsigned LEN_W = $clog2(TOKEN_BYTES);

  typedef enum logic [2:0] {
    M_IDLE, M_COMMENT, M_STRING, M_INT, M_POINT, M_FRAC, M_IDENT
  } mode_e;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FEED, PH_SEMIT, PH_PEND, PH_DBL, PH_CMT, PH_CHAR,
    PH_FINP, PH_FINM, PH_EOF, PH_END
  } phase_e;

  mode_e                    mode_q, mode_d;
  phase_e                   ph_q, ph_d;
  logic [2:0]               pend_q, pend_d;
  logic [LEN_W-1:0]         len_q, len_d;
  logic [8:0]               kwm_q, kwm_d;
  logic                     hold_q, hold_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic [7:0]               ch_q, ch_d;
  logic                     fin_q, fin_d;
  logic                     emitted_q, emitted_d;

  logic                     push_v, done;
  stt_cmd_t                 cmd;
  logic [7:0]               c, app_char, len8;
  logic [5:0]               len6, sk;
  logic [2:0]               pc;
  logic                     is_dig, is_alpha, is_ws, is_quote, app_ok;
  stt_cmd_t                 app_cmd, ident_cmd, flush_cmd;
  logic [8:0]               kw_next, kw_first;
  logic [3:0]               kw_idx;
  logic                     kw_hit;
  logic [POSITION_BITS-1:0] pos_m1, pos_p1;
  logic [POSITION_BITS+15:0] ext_0, ext_m1, ext_p1;
  logic [15:0]              ep_0, ep_m1, ep_p1;

  function automatic stt_cmd_t mk_append(input logic [7:0] ch, input logic [5:0] idx);
    stt_cmd_t r;
    r       = '0;
    r.op    = OP_APPEND;
    r.ch    = ch;
    r.len   = idx;
    return r;
  endfunction

  function automatic stt_cmd_t mk_emit(input src_e s, input logic [5:0] kind,
                                       input logic [7:0] ch, input logic te,
                                       input logic [5:0] len, input logic [3:0] kw);
    stt_cmd_t r;
    r      = '0;
    r.op   = OP_EMIT;
    r.src  = s;
    r.kind = kind;
    r.ch   = ch;
    r.tend = te;
    r.len  = len;
    r.kw   = kw;
    return r;
  endfunction

  function automatic stt_cmd_t mk_error(input logic [2:0] code, input logic [15:0] ep);
    stt_cmd_t r;
    r       = '0;
    r.op    = OP_ERROR;
    r.ecode = code;
    r.epos  = ep;
    return r;
  endfunction

  function automatic logic [8:0] kw_update(input logic [8:0] m, input logic [7:0] l,
                                           input logic [7:0] ch);
    logic [8:0] r;
    r = m;
    for (int k = 0; k < 9; k++) begin
      if (l >= {5'd0, kw_len(4'(k))} || kw_char(4'(k), l[2:0]) != to_upper(ch)) begin
        r[k] = 1'b0;
      end
    end
    return r;
  endfunction

  assign c        = ch_q;
  assign len8     = 8'(len_q);
  assign len6     = TLEN_W'(len_q);
  assign is_dig   = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  assign is_ws    = (c == " ") || (c == 8'h0A) || (c == 8'h0D) || (c == 8'h09);
  assign is_quote = (c == 8'h27) || (c == 8'h22);
  assign sk       = single_kind(c);
  assign pc       = pend_code(c);

  // Error positions are taken modulo the position width, then cut to 16 bits.
  assign pos_m1 = pos_q - POSITION_BITS'(1);
  assign pos_p1 = pos_q + POSITION_BITS'(1);
  assign ext_0  = {16'd0, pos_q};
  assign ext_m1 = {16'd0, pos_m1};
  assign ext_p1 = {16'd0, pos_p1};
  assign ep_0   = ext_0[15:0];
  assign ep_m1  = ext_m1[15:0];
  assign ep_p1  = ext_p1[15:0];

  assign app_ok   = len_q < LEN_W'(TOKEN_BYTES - 1);
  assign app_char = ((mode_q == M_STRING) && is_quote) ? 8'h22 : c;
  assign app_cmd  = app_ok ? mk_append(app_char, len6) : mk_error(E_OVERFLOW, ep_0);
  assign kw_next  = kw_update(kwm_q, len8, c);
  assign kw_first = kw_update(9'h1FF, 8'd0, c);

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = 4'd0;
    for (int k = 8; k >= 0; k--) begin
      if (kwm_q[k] && ({5'd0, kw_len(4'(k))} == len8)) begin
        kw_hit = 1'b1;
        kw_idx = 4'(k);
      end
    end
  end

  assign ident_cmd = kw_hit ?
                     mk_emit(SRC_KW, K_KW0 + {2'd0, kw_idx}, 8'd0, 1'b0,
                             {3'd0, kw_len(kw_idx)}, kw_idx) :
                     mk_emit(SRC_BUF, K_IDENT, 8'd0, 1'b0, len6, 4'd0);

  always_comb begin
    case (mode_q)
      M_COMMENT: flush_cmd = mk_emit(SRC_BUF, K_COMMENT, 8'd0, 1'b0, len6, 4'd0);
      M_INT:     flush_cmd = mk_emit(SRC_BUF, K_INT, 8'd0, 1'b0, len6, 4'd0);
      M_FRAC:    flush_cmd = mk_emit(SRC_BUF, K_FLOAT, 8'd0, 1'b0, len6, 4'd0);
      M_STRING:  flush_cmd = mk_error(E_STRING, ep_0);
      M_POINT:   flush_cmd = mk_error(E_FRACTION, ep_p1);
      M_IDENT:   flush_cmd = ident_cmd;
      default:   flush_cmd = '0;
    endcase
  end

  always_comb begin
    mode_d    = mode_q;
    ph_d      = ph_q;
    pend_d    = pend_q;
    len_d     = len_q;
    kwm_d     = kwm_q;
    hold_d    = hold_q;
    pos_d     = pos_q;
    ch_d      = ch_q;
    fin_d     = fin_q;
    emitted_d = emitted_q;
    push_v    = 1'b0;
    cmd       = '0;
    done      = 1'b0;

    case (ph_q)
      PH_IDLE: begin
        if (in_valid_i) begin
          if (hold_q) begin
            if (final_byte_i) begin
              mode_d = M_IDLE;
              pend_d = 3'd0;
              len_d  = '0;
              pos_d  = '0;
              hold_d = 1'b0;
              kwm_d  = 9'h1FF;
            end
          end else begin
            ch_d      = text_byte_i;
            fin_d     = final_byte_i;
            pos_d     = pos_q + POSITION_BITS'(1);
            emitted_d = 1'b0;
            ph_d      = PH_FEED;
          end
        end
      end

      PH_FEED: begin
        case (mode_q)
          M_COMMENT: begin
            if (c == 8'h0A) begin
              push_v    = 1'b1;
              cmd       = flush_cmd;
              emitted_d = 1'b1;
              mode_d    = M_IDLE;
            end else begin
              push_v    = 1'b1;
              cmd       = app_cmd;
              len_d     = app_ok ? len_q + LEN_W'(1) : len_q;
              hold_d    = hold_q | !app_ok;
              emitted_d = emitted_q | !app_ok;
            end
            done = 1'b1;
          end
          M_STRING: begin
            push_v    = 1'b1;
            cmd       = app_cmd;
            len_d     = app_ok ? len_q + LEN_W'(1) : len_q;
            hold_d    = hold_q | !app_ok;
            emitted_d = emitted_q | !app_ok;
            if (is_quote && app_ok) begin
              ph_d = PH_SEMIT;
            end else begin
              done = 1'b1;
            end
          end
          M_INT, M_FRAC: begin
            if (is_dig || ((mode_q == M_INT) && (c == "."))) begin
              push_v    = 1'b1;
              cmd       = app_cmd;
              len_d     = app_ok ? len_q + LEN_W'(1) : len_q;
              hold_d    = hold_q | !app_ok;
              emitted_d = emitted_q | !app_ok;
              if (!is_dig && app_ok) begin
                mode_d = M_POINT;
              end
              done = 1'b1;
            end else begin
              push_v    = 1'b1;
              cmd       = flush_cmd;
              emitted_d = 1'b1;
              mode_d    = M_IDLE;
              ph_d      = PH_PEND;
            end
          end
          M_POINT: begin
            push_v    = 1'b1;
            emitted_d = emitted_q | !(is_dig && app_ok);
            if (is_dig) begin
              cmd    = app_cmd;
              len_d  = app_ok ? len_q + LEN_W'(1) : len_q;
              hold_d = hold_q | !app_ok;
              if (app_ok) begin
                mode_d = M_FRAC;
              end
            end else begin
              cmd    = mk_error(E_FRACTION, ep_0);
              hold_d = 1'b1;
            end
            done = 1'b1;
          end
          M_IDENT: begin
            push_v = 1'b1;
            if (is_dig || is_alpha) begin
              cmd       = app_cmd;
              kwm_d     = kw_next;
              len_d     = app_ok ? len_q + LEN_W'(1) : len_q;
              hold_d    = hold_q | !app_ok;
              emitted_d = emitted_q | !app_ok;
              done      = 1'b1;
            end else begin
              cmd       = ident_cmd;
              emitted_d = 1'b1;
              mode_d    = M_IDLE;
              ph_d      = PH_PEND;
            end
          end
          default: ph_d = PH_PEND;
        endcase
      end

      PH_SEMIT: begin
        push_v    = 1'b1;
        cmd       = mk_emit(SRC_BUF, K_STRING, 8'd0, 1'b0, len6, 4'd0);
        emitted_d = 1'b1;
        mode_d    = M_IDLE;
        done      = 1'b1;
      end

      PH_PEND: begin
        if (pend_q == 3'd0) begin
          ph_d = PH_CHAR;
        end else if (pend_q == 3'd1) begin
          push_v = 1'b1;
          pend_d = 3'd0;
          if (c == "/") begin
            cmd    = mk_append("/", 6'd0);
            mode_d = M_COMMENT;
            len_d  = LEN_W'(2);
            kwm_d  = 9'h1FF;
            ph_d   = PH_CMT;
          end else begin
            cmd       = mk_emit(SRC_CHR, K_DIVIDE, "/", 1'b1, 6'd1, 4'd0);
            emitted_d = 1'b1;
            ph_d      = PH_CHAR;
          end
        end else if (pend_q >= 3'd6) begin
          push_v    = 1'b1;
          emitted_d = 1'b1;
          if (c == pend_char(pend_q)) begin
            cmd  = mk_emit(SRC_CHR, pend_double(pend_q), c, 1'b0, 6'd1, 4'd0);
            ph_d = PH_DBL;
          end else begin
            cmd    = mk_error(E_UNKNOWN, ep_m1);
            hold_d = 1'b1;
            pend_d = 3'd0;
            done   = 1'b1;
          end
        end else begin
          push_v    = 1'b1;
          emitted_d = 1'b1;
          if (c == "=") begin
            cmd  = mk_emit(SRC_CHR, pend_double(pend_q), pend_char(pend_q), 1'b0,
                           6'd1, 4'd0);
            ph_d = PH_DBL;
          end else begin
            cmd    = mk_emit(SRC_CHR, pend_single(pend_q), pend_char(pend_q), 1'b1,
                             6'd1, 4'd0);
            pend_d = 3'd0;
            ph_d   = PH_CHAR;
          end
        end
      end

      PH_DBL: begin
        push_v = 1'b1;
        cmd    = mk_emit(SRC_CHR, pend_double(pend_q), c, 1'b1, 6'd1, 4'd0);
        pend_d = 3'd0;
        done   = 1'b1;
      end

      PH_CMT: begin
        push_v = 1'b1;
        cmd    = mk_append("/", 6'd1);
        done   = 1'b1;
      end

      PH_CHAR: begin
        done = 1'b1;
        if (is_ws) begin
          push_v = 1'b0;
        end else if (sk != K_NONE) begin
          push_v    = 1'b1;
          cmd       = mk_emit(SRC_CHR, sk, c, 1'b1, 6'd1, 4'd0);
          emitted_d = 1'b1;
        end else if (pc != 3'd0) begin
          pend_d = pc;
        end else if (is_quote) begin
          push_v = 1'b1;
          cmd    = mk_append(8'h22, 6'd0);
          mode_d = M_STRING;
          len_d  = LEN_W'(1);
          kwm_d  = 9'h1FF;
        end else if (is_dig || is_alpha) begin
          push_v = 1'b1;
          cmd    = mk_append(c, 6'd0);
          mode_d = is_dig ? M_INT : M_IDENT;
          len_d  = LEN_W'(1);
          kwm_d  = is_dig ? 9'h1FF : kw_first;
        end else begin
          push_v    = 1'b1;
          cmd       = mk_error(E_UNKNOWN, ep_0);
          hold_d    = 1'b1;
          emitted_d = 1'b1;
        end
      end

      PH_FINP: begin
        ph_d = PH_FINM;
        if (pend_q != 3'd0) begin
          push_v    = 1'b1;
          emitted_d = 1'b1;
          pend_d    = 3'd0;
          if (pend_q >= 3'd6) begin
            cmd    = mk_error(E_UNKNOWN, ep_0);
            hold_d = 1'b1;
          end else begin
            cmd = mk_emit(SRC_CHR, pend_single(pend_q), pend_char(pend_q), 1'b1,
                          6'd1, 4'd0);
          end
        end
      end

      PH_FINM: begin
        ph_d = PH_EOF;
        if (mode_q != M_IDLE) begin
          push_v    = 1'b1;
          cmd       = flush_cmd;
          emitted_d = 1'b1;
          if ((mode_q == M_STRING) || (mode_q == M_POINT)) begin
            hold_d = 1'b1;
          end
        end
      end

      PH_EOF: begin
        ph_d = PH_END;
        if (!hold_q) begin
          push_v    = 1'b1;
          cmd       = mk_emit(SRC_EOF, K_EOF, 8'd0, 1'b0, 6'd3, 4'd0);
          emitted_d = 1'b1;
        end
      end

      PH_END: begin
        if (emitted_q) begin
          push_v = 1'b1;
          cmd    = '0;
          cmd.op = OP_END;
        end
        emitted_d = 1'b0;
        ph_d      = PH_IDLE;
        if (fin_q) begin
          mode_d = M_IDLE;
          pend_d = 3'd0;
          len_d  = '0;
          pos_d  = '0;
          hold_d = 1'b0;
          kwm_d  = 9'h1FF;
        end
      end

      default: ph_d = PH_IDLE;
    endcase

    if (done) begin
      ph_d = (fin_q && !hold_d) ? PH_FINP : PH_END;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= M_IDLE;
      ph_q      <= PH_IDLE;
      pend_q    <= 3'd0;
      len_q     <= '0;
      kwm_q     <= 9'h1FF;
      hold_q    <= 1'b0;
      pos_q     <= '0;
      ch_q      <= 8'd0;
      fin_q     <= 1'b0;
      emitted_q <= 1'b0;
    end else if (!push_v || !full_i) begin
      mode_q    <= mode_d;
      ph_q      <= ph_d;
      pend_q    <= pend_d;
      len_q     <= len_d;
      kwm_q     <= kwm_d;
      hold_q    <= hold_d;
      pos_q     <= pos_d;
      ch_q      <= ch_d;
      fin_q     <= fin_d;
      emitted_q <= emitted_d;
    end
  end

  assign in_stall_o = (ph_q != PH_IDLE);
  assign push_o     = push_v && !full_i;
  assign cmd_o      = cmd;

`include "source_text_tokenizer_assert.svh"

  `STT_ASSERT_ALWAYS(a_pend_only_idle, clk_i, rst_ni, (pend_q == 3'd0) || (mode_q == M_IDLE))
  `STT_ASSERT_ALWAYS(a_len_bound, clk_i, rst_ni, len_q <= LEN_W'(TOKEN_BYTES - 1))

endmodule

`default_nettype wire

@@ sv/stt_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// stt_cmd_fifo
// Short command queue between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_cmd_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  stt_pkg::stt_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output stt_pkg::stt_cmd_t head_o,
  output logic              empty_o
);
  import stt_pkg::*;

  stt_cmd_t               entry_q [CMD_DEPTH];
  logic [CMD_PTR_W-1:0]   wr_q, rd_q;
  logic [CMD_PTR_W:0]     count_q;
  logic                   do_push, do_pop;

  assign full_o  = (count_q == (CMD_PTR_W + 1)'(CMD_DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= wr_q + CMD_PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + CMD_PTR_W'(1);
      end
      count_q <= count_q + (CMD_PTR_W + 1)'(do_push) - (CMD_PTR_W + 1)'(do_pop);
    end
  end

`include "source_text_tokenizer_assert.svh"

  `STT_ASSERT_NEXT(a_push_counts, clk_i, rst_ni, do_push && !do_pop, count_q == $past(count_q) + 1'b1)

endmodule

`default_nettype wire

@@ sv/stt_back.sv @@
// ----------------------------------------------------------------------------
// stt_back
// Carries out commands: writes token text and streams result items.
// ----------------------------------------------------------------------------
`default_nettype none

module stt_back #(
  parameter int unsigned TOKEN_BYTES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  stt_pkg::stt_cmd_t head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output stt_pkg::stt_res_t res_o,
  output logic              run_end_o
);
  import stt_pkg::*;

  localparam int unsigned LEN_W = $clog2(TOKEN_BYTES);

  typedef enum logic [1:0] {B_IDLE, B_READ, B_PUT} bstate_e;

  bstate_e     st_q, st_d;
  stt_cmd_t    cur_q, cur_d;
  logic [5:0]  idx_q, idx_d;
  stt_res_t    stg_q, stg_d, out_q, out_d, res;
  logic        stg_v_q, stg_v_d, ov_q, ov_d, oend_q, oend_d;
  logic        we, out_free, last_chr;
  logic [7:0]  rdata, ch;

  stt_ram #(
    .WIDTH (8),
    .DEPTH (TOKEN_BYTES)
  ) u_text (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (head_i.len[LEN_W-1:0]),
    .wdata_i (head_i.ch),
    .raddr_i (idx_q[LEN_W-1:0]),
    .rdata_o (rdata)
  );

  assign out_free = !ov_q || !out_stall_i;
  assign last_chr = (idx_q == cur_q.len - 6'd1);

  always_comb begin
    case (cur_q.src)
      SRC_BUF: ch = rdata;
      SRC_CHR: ch = cur_q.ch;
      SRC_KW:  ch = kw_char(cur_q.kw, idx_q[2:0]);
      default: ch = eof_char(idx_q[2:0]);
    endcase
    res = '0;
    if (cur_q.op == OP_ERROR) begin
      res.ecode = cur_q.ecode;
      res.epos  = cur_q.epos;
    end else begin
      res.kind = cur_q.kind;
      res.ch   = ch;
      res.tend = (cur_q.src == SRC_CHR) ? cur_q.tend : last_chr;
    end
  end

  always_comb begin
    st_d    = st_q;
    cur_d   = cur_q;
    idx_d   = idx_q;
    stg_d   = stg_q;
    stg_v_d = stg_v_q;
    ov_d    = ov_q && out_stall_i;
    out_d   = out_q;
    oend_d  = oend_q;
    pop_o   = 1'b0;
    we      = 1'b0;
    case (st_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          if (head_i.op == OP_APPEND) begin
            we = 1'b1;
          end else begin
            cur_d = head_i;
            idx_d = 6'd0;
            st_d  = B_READ;
          end
        end
      end
      B_READ: st_d = B_PUT;
      B_PUT: begin
        if (cur_q.op == OP_END) begin
          if (!stg_v_q) begin
            st_d = B_IDLE;
          end else if (out_free) begin
            ov_d    = 1'b1;
            out_d   = stg_q;
            oend_d  = 1'b1;
            stg_v_d = 1'b0;
            st_d    = B_IDLE;
          end
        end else if (!stg_v_q || out_free) begin
          if (stg_v_q) begin
            ov_d   = 1'b1;
            out_d  = stg_q;
            oend_d = 1'b0;
          end
          stg_d   = res;
          stg_v_d = 1'b1;
          if ((cur_q.op == OP_EMIT) && !last_chr) begin
            idx_d = idx_q + 6'd1;
            st_d  = B_READ;
          end else begin
            st_d = B_IDLE;
          end
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    idx_q  <= idx_d;
    stg_q  <= stg_d;
    out_q  <= out_d;
    oend_q <= oend_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= B_IDLE;
      stg_v_q <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      stg_v_q <= stg_v_d;
      ov_q    <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
  assign res_o       = out_q;
  assign run_end_o   = oend_q;

`include "source_text_tokenizer_assert.svh"

  `STT_ASSERT_ALWAYS(a_idx_in_text, clk_i, rst_ni, !((st_q == B_READ) && (cur_q.op == OP_EMIT)) || (idx_q < cur_q.len))
  `STT_ASSERT_NEXT(a_run_close, clk_i, rst_ni, (st_q == B_PUT) && (cur_q.op == OP_END) && stg_v_q && out_free, ov_q && oend_q && !stg_v_q)

endmodule

`default_nettype wire

@@ sv/source_text_tokenizer.sv @@
// ----------------------------------------------------------------------------
// source_text_tokenizer
// Streaming lexer: source bytes in, token text bytes and error reports out.
// ----------------------------------------------------------------------------
// Source text enters one byte per transfer, with final_byte_i marking the last
// byte of a stream. For every finished token the block sends one result
// transfer per text byte, carrying the token kind and marking the last byte
// with token_end_o; keywords come out in upper case, strings re-quoted with a
// double quote, and a stream closes with an EOF token unless an error occurred.
// An error sends a single transfer with a code and the 1-based byte position,
// after which the rest of the stream is dropped. run_end_o marks the last
// result caused by each input byte. A byte that only extends a token passes
// through the phases of the front-end sequencer, which issues at most one
// command per cycle; every result byte then passes through the back-end
// states B_READ, for the token buffer RAM read, and B_PUT, which loads the
// staging register ahead of the output register. A four-entry command queue
// lets the front take the next byte while the back streams an earlier token.
// ----------------------------------------------------------------------------
`default_nettype none

module source_text_tokenizer #(
  parameter int unsigned TOKEN_BYTES   = 32,
  parameter int unsigned POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  text_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [5:0]  token_kind_o,
  output logic [7:0]  token_char_o,
  output logic        token_end_o,
  output logic [2:0]  error_code_o,
  output logic [15:0] error_position_o,
  output logic        run_end_o
);
  import stt_pkg::*;

  // Command path from the front end through the queue to the back end.
  logic     push, full, pop, empty;
  stt_cmd_t cmd, head;
  stt_res_t res;

  // The front end follows the lexer mode and turns each byte into commands.
  stt_front #(
    .TOKEN_BYTES   (TOKEN_BYTES),
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .text_byte_i  (text_byte_i),
    .final_byte_i (final_byte_i),
    .push_o       (push),
    .cmd_o        (cmd),
    .full_i       (full)
  );

  stt_cmd_fifo u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty)
  );

  // The back end owns the token buffer and holds one result back so that the
  // end-of-run mark can be attached once the byte's commands are complete.
  stt_back #(
    .TOKEN_BYTES (TOKEN_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res),
    .run_end_o   (run_end_o)
  );

  assign token_kind_o     = res.kind;
  assign token_char_o     = res.ch;
  assign token_end_o      = res.tend;
  assign error_code_o     = res.ecode;
  assign error_position_o = res.epos;

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Source text tokenizer testbench
// Streams source text into the tokenizer and compares every result transfer
// against a cycle-free model of the lexer held in this file. A short table of
// hand-picked bytes comes first. Random streams of well-formed tokens, with
// noise mixed in, follow under changing idle and stall pressure.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;

  // Token kinds in the order the block numbers them.
  typedef enum logic [5:0] {
    T_MINUS, T_PLUS, T_MULTIPLY, T_ENDLINE, T_OPENPARENT, T_CLOSEPARENT,
    T_OPENBRACE, T_CLOSEBRACE, T_OPENBRACKET, T_CLOSEBRACKET, T_COMMENT,
    T_DIVIDE, T_LENGTH, T_QUESTIONMARK, T_STRING, T_EQU, T_SET, T_GREAEQU,
    T_GREATER, T_LESSEQU, T_LESS, T_NOTEQU, T_NOT, T_AND, T_OR, T_FLOAT,
    T_INT, T_IDENT, T_IF, T_ELSE, T_FOR, T_WHILE, T_LET, T_IN, T_OUT,
    T_TRUE, T_FALSE, T_EOF
  } tok_kind_e;

  typedef enum logic [3:0] {
    LX_IDLE, LX_COMMENT, LX_STRING, LX_INT, LX_POINT, LX_FRAC, LX_IDENT
  } lex_mode_e;

  // Operator character held back while the next byte decides its meaning.
  typedef enum logic [2:0] {
    HO_NONE, HO_SLASH, HO_EQ, HO_GT, HO_LT, HO_BANG, HO_AMP, HO_BAR
  } held_op_e;

  typedef struct packed {
    logic [5:0]  kind;
    logic [7:0]  ch;
    logic        tend;
    logic [2:0]  ecode;
    logic [15:0] epos;
    logic        run_end;
  } tok_res_t;

  // One row of the directed table. Where typed is set the row raises a single
  // error whose code and position are written in by hand.
  typedef struct {
    logic [7:0]  text;
    logic        last;
    bit          typed;
    logic [2:0]  ecode;
    logic [15:0] epos;
  } text_row_t;

  localparam int BUF_BYTES = 32;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [7:0]  text_byte_i;
  logic        final_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [5:0]  token_kind_o;
  logic [7:0]  token_char_o;
  logic        token_end_o;
  logic [2:0]  error_code_o;
  logic [15:0] error_position_o;
  logic        run_end_o;

  source_text_tokenizer DUT (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .text_byte_i, .final_byte_i,
    .out_valid_o, .out_stall_i, .token_kind_o, .token_char_o, .token_end_o,
    .error_code_o, .error_position_o, .run_end_o
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Lexer model: state of the stream being tokenised.
  // --------------------------------------------------------------------------
  lex_mode_e   lx_mode;
  held_op_e    held_op;
  logic [7:0]  tok_buf [BUF_BYTES];
  int          tok_len;
  logic [15:0] pos_cnt;
  bit          err_hold;
  logic [8:0]  kw_live;

  string kw_names [9] = '{"IF", "ELSE", "FOR", "WHILE", "LET", "IN", "OUT",
                          "TRUE", "FALSE"};

  tok_res_t byte_results [$];   // results caused by the byte being modelled
  tok_res_t pending_tokens [$]; // results the block still owes us
  int       fail_count;

  function automatic void clear_stream();
    lx_mode  = LX_IDLE;
    held_op  = HO_NONE;
    tok_len  = 0;
    pos_cnt  = '0;
    err_hold = 1'b0;
    kw_live  = '1;
  endfunction

  function automatic void emit(logic [5:0] kind, logic [7:0] ch, logic tend);
    byte_results.push_back('{kind, ch, tend, stt_pkg::E_NONE, 16'd0, 1'b0});
  endfunction

  function automatic void flag_error(logic [2:0] code, logic [15:0] pos);
    byte_results.push_back('{6'd0, 8'd0, 1'b0, code, pos, 1'b0});
    err_hold = 1'b1;
  endfunction

  function automatic bit add_char(logic [7:0] c, logic [15:0] pos);
    if (tok_len >= BUF_BYTES - 1) begin
      flag_error(stt_pkg::E_OVERFLOW, pos);
      return 1'b0;
    end
    tok_buf[tok_len] = c;
    tok_len++;
    return 1'b1;
  endfunction

  function automatic void emit_buf(logic [5:0] kind);
    for (int i = 0; i < tok_len; i++) emit(kind, tok_buf[i], i == tok_len - 1);
  endfunction

  function automatic void emit_word(logic [5:0] kind, string s);
    for (int i = 0; i < s.len(); i++) emit(kind, s[i], i == s.len() - 1);
  endfunction

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  // Drops every keyword that the next letter of the word rules out.
  function automatic void kw_track(logic [7:0] c);
    logic [7:0] up;
    up = (c >= "a" && c <= "z") ? c - 8'd32 : c;
    for (int k = 0; k < 9; k++)
      if (tok_len >= kw_names[k].len() || kw_names[k][tok_len] != up) kw_live[k] = 1'b0;
  endfunction

  function automatic void close_word();
    for (int k = 0; k < 9; k++)
      if (kw_live[k] && kw_names[k].len() == tok_len) begin
        emit_word(6'(T_IF + k), kw_names[k]);
        return;
      end
    emit_buf(T_IDENT);
  endfunction

  function automatic logic [7:0] op_char(held_op_e p);
    case (p)
      HO_SLASH: return "/";
      HO_EQ:    return "=";
      HO_GT:    return ">";
      HO_LT:    return "<";
      HO_BANG:  return "!";
      HO_AMP:   return "&";
      HO_BAR:   return "|";
      default:  return 8'd0;
    endcase
  endfunction

  function automatic logic [5:0] op_single(held_op_e p);
    case (p)
      HO_SLASH: return T_DIVIDE;
      HO_EQ:    return T_SET;
      HO_GT:    return T_GREATER;
      HO_LT:    return T_LESS;
      default:  return T_NOT;
    endcase
  endfunction

  function automatic logic [5:0] op_double(held_op_e p);
    case (p)
      HO_EQ:   return T_EQU;
      HO_GT:   return T_GREAEQU;
      HO_LT:   return T_LESSEQU;
      HO_BANG: return T_NOTEQU;
      HO_AMP:  return T_AND;
      default: return T_OR;
    endcase
  endfunction

  function automatic logic [5:0] punct_kind(logic [7:0] c);
    case (c)
      "-":     return T_MINUS;
      "+":     return T_PLUS;
      "*":     return T_MULTIPLY;
      ";":     return T_ENDLINE;
      "(":     return T_OPENPARENT;
      ")":     return T_CLOSEPARENT;
      "{":     return T_OPENBRACE;
      "}":     return T_CLOSEBRACE;
      "[":     return T_OPENBRACKET;
      "]":     return T_CLOSEBRACKET;
      "#":     return T_LENGTH;
      "?":     return T_QUESTIONMARK;
      default: return 6'h3f;
    endcase
  endfunction

  // A byte seen between tokens, after any held operator has been resolved.
  function automatic void idle_byte(logic [7:0] c, logic [15:0] pos);
    held_op_e p;
    p = held_op;
    if (p != HO_NONE) begin
      held_op = HO_NONE;
      if (p == HO_SLASH) begin
        if (c == "/") begin
          lx_mode    = LX_COMMENT;
          tok_buf[0] = "/";
          tok_buf[1] = "/";
          tok_len    = 2;
          kw_live    = '1;
          return;
        end
        emit(T_DIVIDE, "/", 1'b1);
      end else if (p == HO_AMP || p == HO_BAR) begin
        if (c == op_char(p)) begin
          emit(op_double(p), c, 1'b0);
          emit(op_double(p), c, 1'b1);
          return;
        end
        // a lone & or | is reported at its own position
        flag_error(stt_pkg::E_UNKNOWN, pos - 16'd1);
        return;
      end else begin
        if (c == "=") begin
          emit(op_double(p), op_char(p), 1'b0);
          emit(op_double(p), "=", 1'b1);
          return;
        end
        emit(op_single(p), op_char(p), 1'b1);
      end
    end
    if (c == " " || c == 8'h0a || c == 8'h0d || c == 8'h09) return;
    if (punct_kind(c) != 6'h3f) begin
      emit(punct_kind(c), c, 1'b1);
      return;
    end
    for (int k = HO_SLASH; k <= HO_BAR; k++)
      if (c == op_char(held_op_e'(k))) begin
        held_op = held_op_e'(k);
        return;
      end
    tok_len = 0;
    kw_live = '1;
    if (c == "'" || c == "\"") begin
      lx_mode    = LX_STRING;
      tok_buf[0] = "\"";
      tok_len    = 1;
    end else if (is_digit(c)) begin
      lx_mode = LX_INT;
      void'(add_char(c, pos));
    end else if (is_alpha(c)) begin
      lx_mode = LX_IDENT;
      kw_track(c);
      void'(add_char(c, pos));
    end else begin
      flag_error(stt_pkg::E_UNKNOWN, pos);
    end
  endfunction

  function automatic void lex_byte(logic [7:0] c, logic [15:0] pos);
    case (lx_mode)
      LX_COMMENT: begin
        if (c == 8'h0a) begin
          emit_buf(T_COMMENT);
          lx_mode = LX_IDLE;
        end else void'(add_char(c, pos));
        return;
      end
      LX_STRING: begin
        if (c == "'" || c == "\"") begin
          if (add_char("\"", pos)) begin
            emit_buf(T_STRING);
            lx_mode = LX_IDLE;
          end
        end else void'(add_char(c, pos));
        return;
      end
      LX_INT: begin
        if (is_digit(c)) begin
          void'(add_char(c, pos));
          return;
        end
        if (c == ".") begin
          if (add_char(c, pos)) lx_mode = LX_POINT;
          return;
        end
        emit_buf(T_INT);
      end
      LX_POINT: begin
        if (!is_digit(c)) flag_error(stt_pkg::E_FRACTION, pos);
        else if (add_char(c, pos)) lx_mode = LX_FRAC;
        return;
      end
      LX_FRAC: begin
        if (is_digit(c)) begin
          void'(add_char(c, pos));
          return;
        end
        emit_buf(T_FLOAT);
      end
      LX_IDENT: begin
        if (is_digit(c) || is_alpha(c)) begin
          kw_track(c);
          void'(add_char(c, pos));
          return;
        end
        close_word();
      end
      default: ;
    endcase
    lx_mode = LX_IDLE;
    idle_byte(c, pos);
  endfunction

  // Flushes whatever is open when the last byte of a stream has been taken.
  function automatic void close_stream(logic [15:0] pos);
    if (held_op != HO_NONE) begin
      if (held_op == HO_AMP || held_op == HO_BAR) flag_error(stt_pkg::E_UNKNOWN, pos);
      else emit(op_single(held_op), op_char(held_op), 1'b1);
      held_op = HO_NONE;
    end
    case (lx_mode)
      LX_COMMENT: emit_buf(T_COMMENT);
      LX_STRING:  flag_error(stt_pkg::E_STRING, pos);
      LX_INT:     emit_buf(T_INT);
      LX_POINT:   flag_error(stt_pkg::E_FRACTION, pos + 16'd1);
      LX_FRAC:    emit_buf(T_FLOAT);
      LX_IDENT:   close_word();
      default: ;
    endcase
    if (!err_hold) emit_word(T_EOF, "EOF");
  endfunction

  // Works out the results of one accepted byte and queues them.
  function automatic void lex_step(logic [7:0] c, logic last);
    logic [15:0] pos;
    byte_results.delete();
    if (err_hold) begin
      if (last) clear_stream();
      return;
    end
    pos = pos_cnt + 16'd1;
    lex_byte(c, pos);
    pos_cnt = pos;
    if (last) begin
      if (!err_hold) close_stream(pos);
      clear_stream();
    end
    if (byte_results.size() > 0) byte_results[byte_results.size() - 1].run_end = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checking. Every accepted result transfer is compared with the
  // oldest outstanding expectation.
  // --------------------------------------------------------------------------
  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk_i) begin
    tok_res_t want;
    tok_res_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{token_kind_o, token_char_o, token_end_o, error_code_o, error_position_o,
              run_end_o};
      if (pending_tokens.size() == 0) begin
        report($sformatf("unexpected result %p", got));
      end else begin
        want = pending_tokens.pop_front();
        if (got.kind != want.kind)
          report($sformatf("token_kind %0d, want %0d", got.kind, want.kind));
        if (got.ch != want.ch)
          report($sformatf("token_char %h, want %h", got.ch, want.ch));
        if (got.tend != want.tend)
          report($sformatf("token_end %b, want %b", got.tend, want.tend));
        if (got.ecode != want.ecode)
          report($sformatf("error_code %0d, want %0d", got.ecode, want.ecode));
        if (got.epos != want.epos)
          report($sformatf("error_position %0d, want %0d", got.epos, want.epos));
        if (got.run_end != want.run_end)
          report($sformatf("run_end %b, want %b", got.run_end, want.run_end));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random stall, plus a long hold-off counted in its own process.
  // --------------------------------------------------------------------------
  int stall_pct;
  bit hold_req;
  bit hold_on;

  initial begin
    hold_on = 1'b0;
    forever begin
      wait (hold_req);
      hold_on = 1'b1;
      repeat (400) @(posedge clk_i);
      hold_on  = 1'b0;
      hold_req = 1'b0;
    end
  end

  always @(negedge clk_i)
    out_stall_i <= hold_on || ($urandom_range(99) < stall_pct);

  // --------------------------------------------------------------------------
  // Sender.
  // --------------------------------------------------------------------------
  int idle_pct;
  int sent_count;

  // Offers one byte from the falling edge and holds it until a transfer. The
  // expectations are worked out at the accepting edge.
  task automatic send_byte(logic [7:0] c, logic last, bit typed = 1'b0,
                           logic [2:0] ecode = 3'd0, logic [15:0] epos = 16'd0);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   = 1'b1;
    text_byte_i  = c;
    final_byte_i = last;
    do @(posedge clk_i); while (in_stall_o);
    lex_step(c, last);
    if (typed) pending_tokens.push_back('{6'd0, 8'd0, 1'b0, ecode, epos, 1'b1});
    else foreach (byte_results[i]) pending_tokens.push_back(byte_results[i]);
    sent_count++;
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] any_but(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    c = 8'($urandom_range(255));
    while (c == a || c == b) c = 8'($urandom_range(255));
    return c;
  endfunction

  // Appends the text of one random token to the stream being built.
  task automatic add_token(ref logic [7:0] s [$]);
    int n;
    string ops;
    logic [7:0] q;
    ops = "-+*;(){}[]#?/=<>!&|";
    case ($urandom_range(9))
      0, 1: begin
        n = $urandom_range(8);
        for (int i = 0; i < kw_names[n].len(); i++)
          s.push_back($urandom_range(1) ? kw_names[n][i] + 8'd32 : kw_names[n][i]);
        if ($urandom_range(4) == 0) s.push_back($urandom_range(1) ? "x" : "7");
      end
      2: begin
        // identifiers, now and then right at the buffer limit
        n = $urandom_range(5) == 0 ? $urandom_range(29, 33) : $urandom_range(1, 8);
        s.push_back(8'("a" + $urandom_range(25)));
        repeat (n - 1)
          case ($urandom_range(2))
            0: s.push_back(8'("a" + $urandom_range(25)));
            1: s.push_back(8'("A" + $urandom_range(25)));
            default: s.push_back(8'("0" + $urandom_range(9)));
          endcase
      end
      3: begin
        repeat ($urandom_range(1, 6)) s.push_back(8'("0" + $urandom_range(9)));
        if ($urandom_range(1)) begin
          s.push_back(".");
          n = $urandom_range(6) == 0 ? 0 : $urandom_range(1, 4);
          repeat (n) s.push_back(8'("0" + $urandom_range(9)));
        end
      end
      4: begin
        q = $urandom_range(1) ? "'" : "\"";
        s.push_back(q);
        n = $urandom_range(5) == 0 ? $urandom_range(28, 31) : $urandom_range(0, 8);
        repeat (n) s.push_back(any_but("'", "\""));
        if ($urandom_range(9) != 0) s.push_back($urandom_range(1) ? "'" : "\"");
      end
      5: begin
        s.push_back("/");
        s.push_back("/");
        n = $urandom_range(5) == 0 ? $urandom_range(27, 31) : $urandom_range(0, 10);
        repeat (n) s.push_back(any_but(8'h0a, 8'h0a));
        if ($urandom_range(3) != 0) s.push_back(8'h0a);
      end
      6, 7, 8: begin
        n = $urandom_range(ops.len() - 1);
        s.push_back(ops[n]);
        case ($urandom_range(3))
          0: s.push_back(ops[n]);
          1: s.push_back("=");
          default: ;
        endcase
      end
      default: s.push_back(8'($urandom_range(255)));
    endcase
  endtask

  // Hand-picked bytes: unknown, fraction, string errors; stream ends that flush
  // a held operator or open comment, keywords, doubled operators and extremes.
  text_row_t lead_rows [] = '{
    '{"+", 1'b1, 1'b0, 3'd0, 16'd0},
    '{"&", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"x", 1'b1, 1'b1, stt_pkg::E_UNKNOWN, 16'd1},
    '{"3", 1'b0, 1'b0, 3'd0, 16'd0},
    '{".", 1'b1, 1'b1, stt_pkg::E_FRACTION, 16'd3},
    '{8'hff, 1'b1, 1'b1, stt_pkg::E_UNKNOWN, 16'd1},
    '{"/", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"/", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"x", 1'b1, 1'b0, 3'd0, 16'd0},
    '{"'", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"a", 1'b1, 1'b1, stt_pkg::E_STRING, 16'd2},
    '{"i", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"F", 1'b0, 1'b0, 3'd0, 16'd0},
    '{" ", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"=", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"=", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"|", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"|", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"<", 1'b1, 1'b0, 3'd0, 16'd0},
    '{"\"", 1'b0, 1'b0, 3'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, 3'd0, 16'd0},
    '{"'", 1'b1, 1'b0, 3'd0, 16'd0},
    '{"9", 1'b0, 1'b0, 3'd0, 16'd0},
    '{".", 1'b0, 1'b0, 3'd0, 16'd0},
    '{"0", 1'b1, 1'b0, 3'd0, 16'd0},
    '{"/", 1'b1, 1'b0, 3'd0, 16'd0}
  };

  initial begin
    logic [7:0] src [$];
    int phase;
    fail_count     = 0;
    sent_count     = 0;
    idle_pct       = 0;
    stall_pct      = 0;
    hold_req       = 1'b0;
    out_stall_i    = 1'b0;
    in_valid_i     = 1'b0;
    text_byte_i    = '0;
    final_byte_i   = 1'b0;
    rst_ni         = 1'b0;
    clear_stream();
    foreach (tok_buf[i]) tok_buf[i] = '0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (lead_rows[i])
      send_byte(lead_rows[i].text, lead_rows[i].last, lead_rows[i].typed,
                lead_rows[i].ecode, lead_rows[i].epos);

    // Random streams in four pressure phases: none, sender idle, receiver
    // stalling, then both a little. The receiver phase opens with a long
    // hold-off while bytes keep coming; the last opens once all is drained.
    phase = 0;
    while (sent_count < 290) begin
      if (sent_count >= 25 + 75 * (phase + 1) && phase < 3) begin
        phase++;
        case (phase)
          1: begin idle_pct = 70; stall_pct = 0; end
          2: begin idle_pct = 0; stall_pct = 70; hold_req = 1'b1; end
          default: begin
            in_valid_i = 1'b0;
            wait (pending_tokens.size() == 0);
            @(negedge clk_i);
            idle_pct  = 15;
            stall_pct = 15;
          end
        endcase
      end
      src.delete();
      repeat ($urandom_range(1, 10)) begin
        add_token(src);
        case ($urandom_range(5))
          0: src.push_back(" ");
          1: src.push_back(8'h09);
          2: src.push_back(8'h0a);
          3: src.push_back(8'h0d);
          default: ;
        endcase
      end
      foreach (src[i]) send_byte(src[i], i == src.size() - 1);
    end

    in_valid_i = 1'b0;
    stall_pct  = 0;
    wait (pending_tokens.size() == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #3000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire

@@ source_text_tokenizer.f @@
+incdir+sv
sv/stt_pkg.sv
sv/stt_ram.sv
sv/stt_front.sv
sv/stt_cmd_fifo.sv
sv/stt_back.sv
sv/source_text_tokenizer.sv
verif/testbench.sv
